FILE: rtl/json_string_unescape_utf8_assert.svh
// Assertion macros for the JSON string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`ifndef SYNTHESIS
`define JSU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("assertion failed");
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("assertion failed");
`else
`define JSU_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/jsu_pkg.sv
// Types, constants and helper functions of the JSON string unescaper.
package jsu_pkg;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_CONTROL   = 3'd1;
   localparam logic [2:0] ST_BAD_ESC   = 3'd2;
   localparam logic [2:0] ST_BAD_HEX   = 3'd3;
   localparam logic [2:0] ST_SURROGATE = 3'd4;
   localparam logic [2:0] ST_BAD_UTF8  = 3'd5;
   localparam logic [2:0] ST_TRUNCATED = 3'd6;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_U         = 8'h75;

   localparam logic [7:0] BYTE_BS = 8'h08;
   localparam logic [7:0] BYTE_FF = 8'h0C;
   localparam logic [7:0] BYTE_LF = 8'h0A;
   localparam logic [7:0] BYTE_CR = 8'h0D;
   localparam logic [7:0] BYTE_HT = 8'h09;

   localparam logic [20:0] CP_MAX       = 21'h10FFFF;
   localparam logic [20:0] CP_SUPP_BASE = 21'h010000;

   typedef struct packed {
      logic        escape_pending;
      logic [2:0]  hex_digits_seen;
      logic [15:0] hex_accumulator;
      logic        low_half_expected;
      logic [9:0]  high_half_bits;
      logic [1:0]  trail_bytes_left;
      logic [1:0]  trail_bytes_total;
      logic [20:0] partial_code_point;
      logic        error_latched;
      logic [2:0]  error_code;
   } jsu_state_type;

   // A group of up to four results caused by one input byte.
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      count;
      logic            byte_valid;
      logic            is_last;
      logic [2:0]      status;
   } jsu_group_type;

   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      count;
   } jsu_utf8_type;

   function automatic logic [2:0] utf8_len(input logic [20:0] v);
      if (v <= 21'h7F) return 3'd1;
      else if (v <= 21'h7FF) return 3'd2;
      else if (v <= 21'hFFFF) return 3'd3;
      else return 3'd4;
   endfunction

   function automatic jsu_utf8_type cp_to_utf8(input logic [20:0] v);
      jsu_utf8_type r;
      r = '0;
      r.count = utf8_len(v);
      unique case (r.count)
         3'd1: r.data[0] = v[7:0];
         3'd2: begin
            r.data[0] = {3'b110, v[10:6]};
            r.data[1] = {2'b10, v[5:0]};
         end
         3'd3: begin
            r.data[0] = {4'b1110, v[15:12]};
            r.data[1] = {2'b10, v[11:6]};
            r.data[2] = {2'b10, v[5:0]};
         end
         default: begin
            r.data[0] = {5'b11110, v[20:18]};
            r.data[1] = {2'b10, v[17:12]};
            r.data[2] = {2'b10, v[11:6]};
            r.data[3] = {2'b10, v[5:0]};
         end
      endcase
      return r;
   endfunction

   // Bit 4 set when the byte is a hexadecimal digit; bits 3:0 give its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return {1'b1, 4'(b - 8'h30)};
      else if (b >= 8'h61 && b <= 8'h66) return {1'b1, 4'(b - 8'h57)};
      else if (b >= 8'h41 && b <= 8'h46) return {1'b1, 4'(b - 8'h37)};
      else return 5'd0;
   endfunction

endpackage

FILE: rtl/jsu_req_if.sv
// Input channel carrying one raw string byte per transfer.
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

FILE: rtl/jsu_rsp_if.sv
// Result channel carrying one unescaped byte or a status per transfer.
interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       is_last;
   logic [2:0] status;

   modport source (output valid, output out_byte, output byte_valid, output is_last,
                   output status, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input is_last,
                 input status, output ready);
endinterface

FILE: rtl/jsu_decode.sv
// Next-state and result-group logic for one input byte.
module jsu_decode (
   input  jsu_pkg::jsu_state_type cur,
   input  logic [7:0]             in_byte,
   input  logic                   end_of_string,
   output jsu_pkg::jsu_state_type nxt,
   output jsu_pkg::jsu_group_type grp,
   output logic                   grp_load
);
   import jsu_pkg::*;

   logic [4:0]   hexd;
   logic [15:0]  hex_x;
   logic         is_high;
   logic         is_low;
   logic [20:0]  pair_cp;
   logic [20:0]  raw_cp;
   jsu_utf8_type enc;

   assign hexd    = hex_digit(in_byte);
   assign hex_x   = {cur.hex_accumulator[11:0], hexd[3:0]};
   assign is_high = hex_x >= 16'hD800 && hex_x <= 16'hDBFF;
   assign is_low  = hex_x >= 16'hDC00 && hex_x <= 16'hDFFF;
   assign pair_cp = {1'b0, cur.high_half_bits, hex_x[9:0]} + CP_SUPP_BASE;
   assign raw_cp  = {cur.partial_code_point[14:0], in_byte[5:0]};

   always_comb begin
      nxt = cur;
      grp = '0;
      grp.byte_valid = 1'b1;
      enc = '0;
      if (!cur.error_latched) begin
         if (cur.escape_pending) begin
            nxt.escape_pending = 1'b0;
            if (cur.low_half_expected && in_byte != CHAR_U) begin
               nxt.error_latched = 1'b1;
               nxt.error_code = ST_SURROGATE;
            end else begin
               unique case (in_byte)
                  CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: begin
                     grp.data[0] = in_byte;
                     grp.count = 3'd1;
                  end
                  CHAR_B: begin grp.data[0] = BYTE_BS; grp.count = 3'd1; end
                  CHAR_F: begin grp.data[0] = BYTE_FF; grp.count = 3'd1; end
                  CHAR_N: begin grp.data[0] = BYTE_LF; grp.count = 3'd1; end
                  CHAR_R: begin grp.data[0] = BYTE_CR; grp.count = 3'd1; end
                  CHAR_T: begin grp.data[0] = BYTE_HT; grp.count = 3'd1; end
                  CHAR_U: begin
                     nxt.hex_digits_seen = 3'd1;
                     nxt.hex_accumulator = '0;
                  end
                  default: begin
                     nxt.error_latched = 1'b1;
                     nxt.error_code = ST_BAD_ESC;
                  end
               endcase
            end
         end else if (cur.hex_digits_seen != 3'd0) begin
            if (!hexd[4]) begin
               nxt.error_latched = 1'b1;
               nxt.error_code = ST_BAD_HEX;
            end else begin
               nxt.hex_accumulator = hex_x;
               if (cur.hex_digits_seen != 3'd4) begin
                  nxt.hex_digits_seen = cur.hex_digits_seen + 3'd1;
               end else begin
                  nxt.hex_digits_seen = 3'd0;
                  if (cur.low_half_expected) begin
                     if (!is_low) begin
                        nxt.error_latched = 1'b1;
                        nxt.error_code = ST_SURROGATE;
                     end else begin
                        nxt.low_half_expected = 1'b0;
                        enc = cp_to_utf8(pair_cp);
                        grp.data = enc.data;
                        grp.count = enc.count;
                     end
                  end else if (is_high) begin
                     nxt.low_half_expected = 1'b1;
                     nxt.high_half_bits = hex_x[9:0];
                  end else if (is_low) begin
                     nxt.error_latched = 1'b1;
                     nxt.error_code = ST_SURROGATE;
                  end else begin
                     enc = cp_to_utf8({5'd0, hex_x});
                     grp.data = enc.data;
                     grp.count = enc.count;
                  end
               end
            end
         end else if (cur.low_half_expected && in_byte != CHAR_BACKSLASH) begin
            nxt.error_latched = 1'b1;
            nxt.error_code = ST_SURROGATE;
         end else if (in_byte <= 8'h1F) begin
            nxt.error_latched = 1'b1;
            nxt.error_code = ST_CONTROL;
         end else if (cur.trail_bytes_left != 2'd0) begin
            if (in_byte[7:6] != 2'b10) begin
               nxt.error_latched = 1'b1;
               nxt.error_code = ST_BAD_UTF8;
            end else begin
               nxt.partial_code_point = raw_cp;
               nxt.trail_bytes_left = cur.trail_bytes_left - 2'd1;
               if (cur.trail_bytes_left == 2'd1) begin
                  if (raw_cp > CP_MAX || (raw_cp >= 21'hD800 && raw_cp <= 21'hDFFF) ||
                      utf8_len(raw_cp) != {1'b0, cur.trail_bytes_total} + 3'd1) begin
                     nxt.error_latched = 1'b1;
                     nxt.error_code = ST_BAD_UTF8;
                  end else begin
                     nxt.trail_bytes_total = 2'd0;
                     nxt.partial_code_point = '0;
                     enc = cp_to_utf8(raw_cp);
                     grp.data = enc.data;
                     grp.count = enc.count;
                  end
               end
            end
         end else if (in_byte == CHAR_BACKSLASH) begin
            nxt.escape_pending = 1'b1;
         end else if (in_byte < 8'h80) begin
            grp.data[0] = in_byte;
            grp.count = 3'd1;
         end else if (in_byte < 8'hC2) begin
            nxt.error_latched = 1'b1;
            nxt.error_code = ST_BAD_UTF8;
         end else if (in_byte < 8'hE0) begin
            nxt.trail_bytes_left = 2'd1;
            nxt.trail_bytes_total = 2'd1;
            nxt.partial_code_point = {16'd0, in_byte[4:0]};
         end else if (in_byte < 8'hF0) begin
            nxt.trail_bytes_left = 2'd2;
            nxt.trail_bytes_total = 2'd2;
            nxt.partial_code_point = {17'd0, in_byte[3:0]};
         end else if (in_byte <= 8'hF4) begin
            nxt.trail_bytes_left = 2'd3;
            nxt.trail_bytes_total = 2'd3;
            nxt.partial_code_point = {18'd0, in_byte[2:0]};
         end else begin
            nxt.error_latched = 1'b1;
            nxt.error_code = ST_BAD_UTF8;
         end
      end

      if (nxt.error_latched) begin
         grp.count = 3'd0;
      end

      if (end_of_string) begin
         if (!nxt.error_latched) begin
            if (nxt.escape_pending || nxt.hex_digits_seen != 3'd0) begin
               nxt.error_latched = 1'b1;
               nxt.error_code = ST_TRUNCATED;
            end else if (nxt.low_half_expected) begin
               nxt.error_latched = 1'b1;
               nxt.error_code = ST_SURROGATE;
            end else if (nxt.trail_bytes_left != 2'd0) begin
               nxt.error_latched = 1'b1;
               nxt.error_code = ST_BAD_UTF8;
            end
         end
         grp.is_last = 1'b1;
         if (nxt.error_latched) begin
            grp.data = '0;
            grp.count = 3'd1;
            grp.byte_valid = 1'b0;
            grp.status = nxt.error_code;
         end else if (grp.count == 3'd0) begin
            grp.count = 3'd1;
            grp.byte_valid = 1'b0;
         end
         nxt = '0;
      end

      grp_load = grp.count != 3'd0;
   end

endmodule

FILE: rtl/json_string_unescape_utf8.sv
// Top level of the streaming JSON string unescaper with UTF-8 validation.
// The first result of a byte appears on rsp_chan in the cycle after that byte's transfer.
// Throughput: one byte per cycle while no result is held or the last one drains; a byte
// that yields up to four results holds the single result register until each is taken.
// Reset: synchronous, active high; clears the decode state and empties the result register.
`include "json_string_unescape_utf8_assert.svh"
module json_string_unescape_utf8 (
   input logic    clock,
   input logic    reset,
   jsu_req_if.sink   req_chan,
   jsu_rsp_if.source rsp_chan
);
   import jsu_pkg::*;

   jsu_state_type state_ff;
   jsu_state_type state_in;
   jsu_group_type grp_ff;
   jsu_group_type grp_in;
   logic          grp_load;
   logic          busy_ff;
   logic [1:0]    idx_ff;
   logic [2:0]    count_m1;
   logic          last_beat;
   logic          drain;
   logic          req_take;
   logic          rsp_take;
   logic          end_take;

   jsu_decode u_decode (
      .cur           (state_ff),
      .in_byte       (req_chan.in_byte),
      .end_of_string (req_chan.end_of_string),
      .nxt           (state_in),
      .grp           (grp_in),
      .grp_load      (grp_load)
   );

   assign count_m1  = grp_ff.count - 3'd1;
   assign last_beat = {1'b0, idx_ff} == count_m1;
   assign rsp_take  = busy_ff && rsp_chan.ready;
   assign drain     = rsp_take && last_beat;
   assign req_chan.ready = !busy_ff || drain;
   assign req_take  = req_chan.valid && req_chan.ready;
   assign end_take  = req_take && req_chan.end_of_string;

   assign rsp_chan.valid      = busy_ff;
   assign rsp_chan.out_byte   = grp_ff.data[idx_ff];
   assign rsp_chan.byte_valid = grp_ff.byte_valid;
   assign rsp_chan.is_last    = grp_ff.is_last && last_beat;
   assign rsp_chan.status     = grp_ff.status;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         busy_ff  <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (req_take) begin
            state_ff <= state_in;
         end
         if (req_take && grp_load) begin
            busy_ff <= 1'b1;
            idx_ff  <= 2'd0;
         end else if (drain) begin
            busy_ff <= 1'b0;
            idx_ff  <= 2'd0;
         end else if (rsp_take) begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && grp_load) begin
         grp_ff <= grp_in;
      end
   end

   `JSU_ASSERT_IMPLY(a_status_only_last, clock, reset, busy_ff && !grp_ff.byte_valid, rsp_chan.is_last)
   `JSU_ASSERT_IMPLY(a_data_ok, clock, reset, busy_ff && grp_ff.byte_valid, rsp_chan.status == ST_OK)
   `JSU_ASSERT_NEXT(a_end_clears, clock, reset, end_take, state_ff == '0)
   `JSU_ASSERT_IMPLY(a_no_take_busy, clock, reset, req_take, !busy_ff || drain)

endmodule
